>>> design/pidis_pkg.sv
// ----------------------------------------------------------------------------
// pidis_pkg
// Shared types and constants of the PID controller with integral separation.
// ----------------------------------------------------------------------------
package pidis_pkg;

	localparam int unsigned DataW  = 32;
	localparam int unsigned BandW  = 31;
	localparam int unsigned IntegW = 48;
	localparam int unsigned IndexW = 3;

	localparam logic [BandW-1:0] BandReset  = 31'd65536000;
	localparam logic [BandW-1:0] ClampReset = 31'h7FFF_FFFF;

	typedef enum logic [IndexW-1:0] {
		REG_GAIN_P          = 3'd0,
		REG_GAIN_I          = 3'd1,
		REG_GAIN_D          = 3'd2,
		REG_SEPARATION_BAND = 3'd3,
		REG_ERROR_CLAMP     = 3'd4,
		REG_DERIVATIVE_MODE = 3'd5
	} reg_index_t;

	typedef enum logic [1:0] {
		DMODE_NONE       = 2'd0,
		DMODE_ERROR_DIFF = 2'd1,
		DMODE_RATE       = 2'd2
	} dmode_t;

	typedef struct packed {
		logic signed [DataW-1:0] gain_p;
		logic signed [DataW-1:0] gain_i;
		logic signed [DataW-1:0] gain_d;
		logic        [BandW-1:0] separation_band;
		logic        [BandW-1:0] error_clamp;
		logic        [1:0]       derivative_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [DataW-1:0] setpoint;
		logic signed [DataW-1:0] measured;
		logic signed [DataW-1:0] measured_rate;
		logic                    integral_clear;
	} sample_t;

	typedef struct packed {
		logic signed [IntegW-1:0] integrator;
		logic signed [DataW-1:0]  previous_error;
	} state_t;

endpackage

>>> design/pidis_if.sv
// ----------------------------------------------------------------------------
// pidis_sample_if / pidis_result_if
// Valid/ready channels carrying input samples and drive results.
// ----------------------------------------------------------------------------
interface pidis_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] setpoint;
	logic signed [31:0] measured;
	logic signed [31:0] measured_rate;
	logic               integral_clear;

	modport source (output valid, output setpoint, output measured,
		output measured_rate, output integral_clear, input ready);
	modport sink (input valid, input setpoint, input measured,
		input measured_rate, input integral_clear, output ready);
endinterface

interface pidis_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

>>> design/pidis_cfg.sv
// ----------------------------------------------------------------------------
// pidis_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module pidis_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pidis_pkg::IndexW-1:0] cfg_index,
	input  logic [pidis_pkg::DataW-1:0]  cfg_data,
	output pidis_pkg::cfg_t              cfg
);
	import pidis_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p          <= '0;
			cfg_q.gain_i          <= '0;
			cfg_q.gain_d          <= '0;
			cfg_q.separation_band <= BandReset;
			cfg_q.error_clamp     <= ClampReset;
			cfg_q.derivative_mode <= DMODE_ERROR_DIFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P:          cfg_q.gain_p          <= cfg_data;
				REG_GAIN_I:          cfg_q.gain_i          <= cfg_data;
				REG_GAIN_D:          cfg_q.gain_d          <= cfg_data;
				REG_SEPARATION_BAND: cfg_q.separation_band <= cfg_data[BandW-1:0];
				REG_ERROR_CLAMP:     cfg_q.error_clamp     <= cfg_data[BandW-1:0];
				REG_DERIVATIVE_MODE: cfg_q.derivative_mode <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/pidis_calc.sv
// ----------------------------------------------------------------------------
// pidis_calc
// Single-pass PID arithmetic: error clamp, P, I with separation, D, drive.
// ----------------------------------------------------------------------------
module pidis_calc (
	input  pidis_pkg::cfg_t                   cfg,
	input  pidis_pkg::sample_t                sample,
	input  pidis_pkg::state_t                 state,
	output pidis_pkg::state_t                 state_next,
	output logic signed [pidis_pkg::DataW-1:0] drive
);
	import pidis_pkg::*;

	logic signed [DataW:0]     diff;
	logic signed [DataW:0]     lim_hi;
	logic signed [DataW:0]     lim_lo;
	logic signed [DataW-1:0]   err;
	logic        [DataW-1:0]   abs_err;
	logic signed [2*DataW-1:0] prod_p;
	logic signed [2*DataW-1:0] prod_i;
	logic signed [2*DataW-1:0] prod_d;
	logic signed [2*DataW-1:0] neg_d;
	logic signed [DataW:0]     ediff;
	logic signed [DataW-1:0]   ediff_sat;
	logic signed [DataW-1:0]   d_operand;
	logic signed [IntegW-1:0]  term_p;
	logic signed [IntegW-1:0]  term_d;
	logic signed [IntegW:0]    integ_sum;
	logic signed [IntegW-1:0]  integ_sat;
	logic signed [IntegW-1:0]  integ_new;
	logic signed [IntegW+1:0]  total;
	logic signed [IntegW-15:0] quot;
	logic signed [IntegW-15:0] quot_t;

	always_comb begin
		diff   = {sample.setpoint[DataW-1], sample.setpoint}
			- {sample.measured[DataW-1], sample.measured};
		lim_hi = {2'b00, cfg.error_clamp};
		lim_lo = -lim_hi;
		if (diff > lim_hi) begin
			err = lim_hi[DataW-1:0];
		end else if (diff < lim_lo) begin
			err = lim_lo[DataW-1:0];
		end else begin
			err = diff[DataW-1:0];
		end
		abs_err = err[DataW-1] ? DataW'(-err) : DataW'(err);

		prod_p = err * cfg.gain_p;
		prod_i = err * cfg.gain_i;
		term_p = prod_p[2*DataW-1:16];

		integ_sum = {state.integrator[IntegW-1], state.integrator}
			+ {prod_i[2*DataW-1], prod_i[2*DataW-1:16]};
		if (integ_sum[IntegW] != integ_sum[IntegW-1]) begin
			integ_sat = integ_sum[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
				: {1'b0, {(IntegW-1){1'b1}}};
		end else begin
			integ_sat = integ_sum[IntegW-1:0];
		end
		if (sample.integral_clear || (abs_err > {1'b0, cfg.separation_band})) begin
			integ_new = '0;
		end else begin
			integ_new = integ_sat;
		end

		ediff = {err[DataW-1], err}
			- {state.previous_error[DataW-1], state.previous_error};
		if (ediff[DataW] != ediff[DataW-1]) begin
			ediff_sat = ediff[DataW] ? {1'b1, {(DataW-1){1'b0}}}
				: {1'b0, {(DataW-1){1'b1}}};
		end else begin
			ediff_sat = ediff[DataW-1:0];
		end

		case (cfg.derivative_mode)
			DMODE_ERROR_DIFF: d_operand = ediff_sat;
			DMODE_RATE:       d_operand = sample.measured_rate;
			default:          d_operand = '0;
		endcase
		prod_d = cfg.gain_d * d_operand;
		neg_d  = -prod_d;
		term_d = neg_d[2*DataW-1:16];

		total = {{2{term_p[IntegW-1]}}, term_p} + {{2{integ_new[IntegW-1]}}, integ_new}
			+ {{2{term_d[IntegW-1]}}, term_d};
		quot = total[IntegW+1:16];
		if (total[IntegW+1] && (total[15:0] != '0)) begin
			quot_t = quot + 1'b1;
		end else begin
			quot_t = quot;
		end
		if (quot_t > $signed({3'b000, {(DataW-1){1'b1}}})) begin
			drive = {1'b0, {(DataW-1){1'b1}}};
		end else if (quot_t < $signed({3'b111, {(DataW-1){1'b0}}})) begin
			drive = {1'b1, {(DataW-1){1'b0}}};
		end else begin
			drive = quot_t[DataW-1:0];
		end

		state_next.integrator     = integ_new;
		state_next.previous_error = err;
	end

endmodule

>>> design/pid_with_integral_separation.sv
// ----------------------------------------------------------------------------
// pid_with_integral_separation
// PID controller in signed Q16.16 with integral separation and selectable D.
// ----------------------------------------------------------------------------
// Samples arrive on the sample channel and each transfer yields exactly one
// drive value on the result channel, in order. Gains, the separation band,
// the error clamp and the derivative mode are set through the write port,
// which must only be used while no sample is in flight.
// A sample is held in an input register on the edge of its transfer, and its
// drive value is then registered in the output register, which presents it
// on the result channel. The arithmetic for one sample is a single pass of
// three parallel 32 by 32 multipliers and the integrator update, so one
// sample is taken in every cycle while the receiver does not stall.
// When the receiver stalls, the finished result waits in the output register
// while the next sample is still taken into the input register; only when
// both are full is ready withdrawn. Reset empties both registers, clears the
// integrator and the stored error, and loads the register reset values.
// ----------------------------------------------------------------------------
module pid_with_integral_separation (
	input  logic                         clk,
	input  logic                         arst_n,
	pidis_sample_if.sink                 sample,
	pidis_result_if.source               result,
	input  logic                         cfg_we,
	input  logic [pidis_pkg::IndexW-1:0] cfg_index,
	input  logic [pidis_pkg::DataW-1:0]  cfg_data
);
	import pidis_pkg::*;

	cfg_t                    cfg;
	sample_t                 sample_s1;
	logic                    valid_s1;
	state_t                  state_q;
	state_t                  state_next;
	logic signed [DataW-1:0] drive_calc;
	logic signed [DataW-1:0] drive_q;
	logic                    valid_q;
	logic                    advance;

	pidis_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidis_calc u_calc (
		.cfg        (cfg),
		.sample     (sample_s1),
		.state      (state_q),
		.state_next (state_next),
		.drive      (drive_calc)
	);

	assign advance      = valid_s1 && (!valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			sample_s1.setpoint       <= sample.setpoint;
			sample_s1.measured       <= sample.measured;
			sample_s1.measured_rate  <= sample.measured_rate;
			sample_s1.integral_clear <= sample.integral_clear;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			state_q <= '0;
		end else if (advance) begin
			valid_q <= 1'b1;
			state_q <= state_next;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_q <= drive_calc;
		end
	end

	assign result.valid = valid_q;
	assign result.drive = drive_q;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the PID controller with integral separation.
// A directed table drives the field extremes, every derivative mode, error
// clamping, integrator and drive saturation, integral separation and clear,
// and writes to unused register indexes. Random phases with random settings
// follow. Every drive value is compared in order with a fixed table value or
// with a predictor that keeps its own settings, integrator and previous error.
// Both channels idle in random bursts, and the last phase runs without them.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import pidis_pkg::*;

	localparam logic [IndexW-1:0] REG_UNKNOWN_LO = 3'd6;
	localparam logic [IndexW-1:0] REG_UNKNOWN_HI = 3'd7;
	localparam logic [1:0]        DMODE_UNUSED   = 2'd3;

	localparam int                   QShift        = 16;
	localparam int                   QOne          = 1 << QShift;
	localparam longint               QScale        = 64'sd65536;
	localparam longint               IntegMax      = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint               IntegMin      = -IntegMax - 1;
	localparam longint               Sat32Max      = 64'sh0000_0000_7FFF_FFFF;
	localparam longint               Sat32Min      = -Sat32Max - 1;
	localparam logic signed [31:0]   S32Max        = 32'sh7FFF_FFFF;
	localparam logic signed [31:0]   S32Min        = 32'sh8000_0000;
	localparam logic [BandW-1:0]     U31Max        = 31'h7FFF_FFFF;
	localparam int                   ResetCycles   = 6;
	localparam int                   WatchdogLimit = 400;
	localparam int                   TailCycles    = 20;
	localparam int                   RandomPhases  = 10;
	localparam int                   PhaseItems    = 125;

	typedef struct {
		int                      setting;
		sample_t                 stim;
		bit                      fixed;
		logic signed [DataW-1:0] fixed_drive;
	} directed_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [IndexW-1:0]   cfg_index;
	logic [DataW-1:0]    cfg_data;

	pidis_sample_if sample_ch ();
	pidis_result_if result_ch ();

	pid_with_integral_separation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cfg_t                    ctrl_cfg;
	longint                  integ_acc;
	longint                  last_error;
	logic signed [DataW-1:0] drive_queue[$];
	logic signed [DataW-1:0] want_drive;
	directed_row_t           directed_rows[$];
	cfg_t                    directed_settings[6];
	int                      current_setting;
	int                      error_count;
	int                      quiet_cycles;
	int                      stall_left;
	bit                      bursts_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic logic signed [DataW-1:0] predict_drive(input sample_t s);
		longint lim, err, mag, gp, gi, gd, p_term, d_term, diff, whole;
		lim = longint'(ctrl_cfg.error_clamp);
		gp = longint'($signed(ctrl_cfg.gain_p));
		gi = longint'($signed(ctrl_cfg.gain_i));
		gd = longint'($signed(ctrl_cfg.gain_d));
		err = longint'($signed(s.setpoint)) - longint'($signed(s.measured));
		if (err > lim)
			err = lim;
		else if (err < -lim)
			err = -lim;
		p_term = (err * gp) >>> QShift;
		integ_acc = integ_acc + ((err * gi) >>> QShift);
		if (integ_acc > IntegMax)
			integ_acc = IntegMax;
		else if (integ_acc < IntegMin)
			integ_acc = IntegMin;
		mag = (err < 0) ? -err : err;
		if (s.integral_clear || mag > longint'(ctrl_cfg.separation_band))
			integ_acc = 0;
		case (ctrl_cfg.derivative_mode)
			DMODE_ERROR_DIFF: begin
				diff = err - last_error;
				if (diff > Sat32Max)
					diff = Sat32Max;
				else if (diff < Sat32Min)
					diff = Sat32Min;
				d_term = (-(gd * diff)) >>> QShift;
			end
			DMODE_RATE: d_term = (-(gd * longint'($signed(s.measured_rate)))) >>> QShift;
			default: d_term = 0;
		endcase
		last_error = err;
		whole = (p_term + integ_acc + d_term) / QScale;
		if (whole > Sat32Max)
			whole = Sat32Max;
		else if (whole < Sat32Min)
			whole = Sat32Min;
		return whole[DataW-1:0];
	endfunction

	function automatic cfg_t settings(input logic signed [DataW-1:0] gp,
		input logic signed [DataW-1:0] gi, input logic signed [DataW-1:0] gd,
		input logic [BandW-1:0] band, input logic [BandW-1:0] clamp,
		input logic [1:0] mode);
		cfg_t c;
		c.gain_p          = gp;
		c.gain_i          = gi;
		c.gain_d          = gd;
		c.separation_band = band;
		c.error_clamp     = clamp;
		c.derivative_mode = mode;
		return c;
	endfunction

	function automatic directed_row_t directed_row(input int setting,
		input logic signed [DataW-1:0] sp, input logic signed [DataW-1:0] meas,
		input logic signed [DataW-1:0] rate, input logic clr, input bit fixed,
		input logic signed [DataW-1:0] drive);
		directed_row_t r;
		r.setting                  = setting;
		r.stim.setpoint            = sp;
		r.stim.measured            = meas;
		r.stim.measured_rate       = rate;
		r.stim.integral_clear      = clr;
		r.fixed                    = fixed;
		r.fixed_drive              = drive;
		return r;
	endfunction

	function automatic logic signed [DataW-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return S32Min;
			1: return S32Max;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return 32'sd1;
		endcase
	endfunction

	function automatic logic signed [DataW-1:0] pick_gain();
		case ($urandom_range(0, 3))
			0: return pick_extreme();
			1: return $urandom;
			default: return int'($urandom_range(0, 16 * QOne)) - 8 * QOne;
		endcase
	endfunction

	function automatic cfg_t random_settings();
		logic [BandW-1:0] band, clamp;
		case ($urandom_range(0, 5))
			0: band = '0;
			1: band = U31Max;
			2: band = BandReset;
			default: band = 31'($urandom_range(0, 200 * QOne));
		endcase
		case ($urandom_range(0, 7))
			0: clamp = '0;
			1: clamp = U31Max;
			2: clamp = 31'($urandom);
			default: clamp = 31'($urandom_range(QOne, 3000 * QOne));
		endcase
		return settings(pick_gain(), pick_gain(), pick_gain(), band, clamp,
			2'($urandom_range(0, 3)));
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		case ($urandom_range(0, 9))
			0: begin
				s.setpoint = pick_extreme();
				s.measured = pick_extreme();
			end
			1, 2: begin
				s.setpoint = $urandom;
				s.measured = $urandom;
			end
			default: begin
				s.setpoint = $urandom;
				s.measured = s.setpoint + (int'($urandom_range(0, 128 * QOne)) - 64 * QOne);
			end
		endcase
		case ($urandom_range(0, 3))
			0: s.measured_rate = pick_extreme();
			1: s.measured_rate = int'($urandom_range(0, 32 * QOne)) - 16 * QOne;
			default: s.measured_rate = $urandom;
		endcase
		s.integral_clear = ($urandom_range(0, 15) == 0);
		return s;
	endfunction

	task automatic write_register(input logic [IndexW-1:0] idx, input logic [DataW-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_GAIN_P:          ctrl_cfg.gain_p = data;
			REG_GAIN_I:          ctrl_cfg.gain_i = data;
			REG_GAIN_D:          ctrl_cfg.gain_d = data;
			REG_SEPARATION_BAND: ctrl_cfg.separation_band = data[BandW-1:0];
			REG_ERROR_CLAMP:     ctrl_cfg.error_clamp = data[BandW-1:0];
			REG_DERIVATIVE_MODE: ctrl_cfg.derivative_mode = data[1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input cfg_t s);
		write_register(REG_UNKNOWN_LO, $urandom);
		write_register(REG_GAIN_P, s.gain_p);
		write_register(REG_GAIN_I, s.gain_i);
		write_register(REG_GAIN_D, s.gain_d);
		write_register(REG_SEPARATION_BAND, {1'($urandom_range(0, 1)), s.separation_band});
		write_register(REG_ERROR_CLAMP, {1'($urandom_range(0, 1)), s.error_clamp});
		write_register(REG_DERIVATIVE_MODE, {30'($urandom), s.derivative_mode});
		write_register(REG_UNKNOWN_HI, $urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (drive_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_sample(input sample_t s, input bit fixed,
		input logic signed [DataW-1:0] fixed_drive);
		logic signed [DataW-1:0] predicted;
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		sample_ch.valid          <= 1'b1;
		sample_ch.setpoint       <= s.setpoint;
		sample_ch.measured       <= s.measured;
		sample_ch.measured_rate  <= s.measured_rate;
		sample_ch.integral_clear <= s.integral_clear;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		predicted = predict_drive(s);
		drive_queue.push_back(fixed ? fixed_drive : predicted);
	endtask

	initial begin
		result_ch.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && bursts_on && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 12);
			result_ch.ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (drive_queue.size() == 0) begin
				report_mismatch($sformatf("drive %0d with no sample waiting", result_ch.drive));
			end else begin
				want_drive = drive_queue.pop_front();
				if (result_ch.drive !== want_drive)
					report_mismatch($sformatf("drive %0d, expected %0d",
						result_ch.drive, want_drive));
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WatchdogLimit) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		error_count = 0;
		bursts_on   = 1'b1;
		integ_acc   = 0;
		last_error  = 0;
		ctrl_cfg    = settings('0, '0, '0, BandReset, ClampReset, DMODE_ERROR_DIFF);

		arst_n                   <= 1'b0;
		cfg_we                   <= 1'b0;
		cfg_index                <= '0;
		cfg_data                 <= '0;
		sample_ch.valid          <= 1'b0;
		sample_ch.setpoint       <= '0;
		sample_ch.measured       <= '0;
		sample_ch.measured_rate  <= '0;
		sample_ch.integral_clear <= 1'b0;

		directed_settings[0] = ctrl_cfg;
		directed_settings[1] = settings(QOne, '0, '0, BandReset, U31Max, DMODE_NONE);
		directed_settings[2] = settings(QOne, '0, '0, BandReset, 31'(10 * QOne), DMODE_NONE);
		directed_settings[3] = settings(S32Max, S32Max, S32Min, U31Max, U31Max,
			DMODE_ERROR_DIFF);
		directed_settings[4] = settings(S32Min, S32Min, S32Min, U31Max, U31Max, DMODE_RATE);
		directed_settings[5] = settings(QOne, QOne, QOne, 31'(5 * QOne), U31Max,
			DMODE_UNUSED);

		directed_rows.push_back(directed_row(0, S32Max, S32Min, S32Max, 1'b0, 1'b1, 0));
		directed_rows.push_back(directed_row(0, S32Min, S32Max, S32Min, 1'b1, 1'b1, 0));
		directed_rows.push_back(directed_row(0, 0, 0, 0, 1'b0, 1'b1, 0));
		directed_rows.push_back(directed_row(1, 100 * QOne, 0, 0, 1'b0, 1'b1, 100));
		directed_rows.push_back(directed_row(1, 0, 100 * QOne, S32Max, 1'b1, 1'b1, -100));
		directed_rows.push_back(directed_row(1, S32Max, S32Min, 0, 1'b0, 1'b1, 32767));
		directed_rows.push_back(directed_row(1, S32Min, S32Max, S32Min, 1'b0, 1'b1, -32767));
		directed_rows.push_back(directed_row(1, 0, 1, 0, 1'b0, 1'b1, 0));
		directed_rows.push_back(directed_row(1, 0, 3 * QOne / 2, 0, 1'b0, 1'b1, -1));
		directed_rows.push_back(directed_row(2, 1000 * QOne, 0, 0, 1'b0, 1'b1, 10));
		directed_rows.push_back(directed_row(2, 0, 1000 * QOne, 0, 1'b0, 1'b1, -10));
		directed_rows.push_back(directed_row(3, S32Max, S32Min, 0, 1'b0, 1'b0, 0));
		directed_rows.push_back(directed_row(3, S32Max, S32Min, 0, 1'b0, 1'b0, 0));
		directed_rows.push_back(directed_row(3, S32Max, S32Min, 0, 1'b0, 1'b0, 0));
		directed_rows.push_back(directed_row(3, S32Min, S32Max, S32Max, 1'b0, 1'b0, 0));
		directed_rows.push_back(directed_row(3, S32Max, S32Min, S32Min, 1'b0, 1'b0, 0));
		directed_rows.push_back(directed_row(3, 0, 0, 0, 1'b1, 1'b0, 0));
		directed_rows.push_back(directed_row(4, S32Max, S32Min, S32Min, 1'b0, 1'b0, 0));
		directed_rows.push_back(directed_row(4, S32Max, S32Min, S32Max, 1'b0, 1'b0, 0));
		directed_rows.push_back(directed_row(4, S32Max, S32Min, 0, 1'b0, 1'b0, 0));
		directed_rows.push_back(directed_row(5, 3 * QOne, 0, S32Max, 1'b0, 1'b0, 0));
		directed_rows.push_back(directed_row(5, 3 * QOne, 0, 0, 1'b0, 1'b0, 0));
		directed_rows.push_back(directed_row(5, 10 * QOne, 0, 0, 1'b0, 1'b0, 0));
		directed_rows.push_back(directed_row(5, 3 * QOne, 0, 0, 1'b1, 1'b0, 0));

		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first rows run on the reset values of the registers.
		current_setting = 0;
		foreach (directed_rows[n]) begin
			if (directed_rows[n].setting != current_setting) begin
				drain_results();
				load_settings(directed_settings[directed_rows[n].setting]);
				current_setting = directed_rows[n].setting;
			end
			send_sample(directed_rows[n].stim, directed_rows[n].fixed,
				directed_rows[n].fixed_drive);
		end

		for (int phase = 0; phase < RandomPhases; phase++) begin
			drain_results();
			load_settings(random_settings());
			bursts_on = (phase < RandomPhases - 1) && ($urandom_range(0, 3) != 0);
			repeat (PhaseItems) send_sample(random_sample(), 1'b0, '0);
		end

		drain_results();
		repeat (TailCycles) @(posedge clk);
		if (drive_queue.size() != 0)
			report_mismatch($sformatf("%0d drive values never arrived", drive_queue.size()));

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
